>>> src/srps_pkg.sv
// shared types and codes for the source route packet step core
// no dependencies; imported by source_route_packet_step_core
package srps_pkg;

  typedef logic [31:0] addr_t;
  typedef logic [2:0]  code_t;

  // packet type codes
  localparam code_t PTYPE_REQUEST = 3'd0;
  localparam code_t PTYPE_REPLY   = 3'd1;
  localparam code_t PTYPE_ERROR   = 3'd2;
  localparam code_t PTYPE_DATA    = 3'd3;

  // verdict codes
  localparam code_t VERDICT_DROP     = 3'd0;
  localparam code_t VERDICT_FORWARD  = 3'd1;
  localparam code_t VERDICT_REPLY    = 3'd2;
  localparam code_t VERDICT_ERROR    = 3'd3;
  localparam code_t VERDICT_DATA     = 3'd4;
  localparam code_t VERDICT_OVERFLOW = 3'd5;

  // configuration register indexes
  localparam logic CFG_OWN_ADDRESS       = 1'b0;
  localparam logic CFG_BROADCAST_ADDRESS = 1'b1;

endpackage

>>> src/source_route_packet_step_core.sv
// route-record step of a source-routing node: entry matching, record store and replay
// depends on srps_pkg (types, packet type and verdict codes)
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | packet_type, source/dest/entry_address,
//           |           |                         | last_entry
//   out     | output    | out_valid_o/out_stall_i | verdict, type_out, source_out, dest_out,
//           |           |                         | route_entry, route_length, next_hop, last
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// each entry is taken in the accept state, then makes one pass through the shared address compare
// after the last entry a judge step decides the packet on the same comparator, then each result
// goes through store read, load and present, and stays presented while out_stall_i is held high
// a drop or overflow result skips the store read and is presented right after the judge cycle
// in_stall_o stays high from an accept until its match pass ends, and from the last entry until
// the final result transaction of the packet completes
// the route store needs no clearing pass; reset clears control and header state at once
module source_route_packet_step_core #(
  parameter int MAX_ROUTE     = 16,
  parameter int ADDRESS_BYTES = 4,
  localparam int LW = $clog2(MAX_ROUTE + 2)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  srps_pkg::addr_t cfg_data_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srps_pkg::code_t packet_type_i,
  input  srps_pkg::addr_t source_address_i,
  input  srps_pkg::addr_t dest_address_i,
  input  srps_pkg::addr_t entry_address_i,
  input  logic            last_entry_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output srps_pkg::code_t verdict_o,
  output srps_pkg::code_t type_out_o,
  output srps_pkg::addr_t source_out_o,
  output srps_pkg::addr_t dest_out_o,
  output srps_pkg::addr_t route_entry_o,
  output logic [LW-1:0]   route_length_o,
  output srps_pkg::addr_t next_hop_o,
  output logic            last_o
);
  import srps_pkg::*;

  localparam int CW = $clog2(MAX_ROUTE + 1);
  localparam int IW = $clog2(MAX_ROUTE);
  localparam addr_t ADDR_MASK = (ADDRESS_BYTES >= 4) ? 32'hFFFF_FFFF :
                                32'((64'd1 << (8 * ADDRESS_BYTES)) - 64'd1);

  typedef enum logic [2:0] {
    S_IN,
    S_MATCH,
    S_JUDGE,
    S_FETCH,
    S_LOAD,
    S_OUT
  } state_e;

  state_e        state_q;
  addr_t         own_q, bcast_q;
  addr_t         entry_q;
  logic          last_in_q;
  code_t         hdr_type_q;
  addr_t         hdr_src_q, hdr_dst_q;
  logic [CW-1:0] cnt_q;
  logic          own_seen_q, found_q, ovf_q;
  addr_t         prev_q, rhop_q, held_q;
  logic          append_q;
  logic [CW-1:0] rd_idx_q;
  addr_t         rd_data_q;
  addr_t         route_mem [MAX_ROUTE];

  code_t         verdict_q, type_q;
  addr_t         src_out_q, dst_out_q, rentry_q, hop_q;
  logic [LW-1:0] len_q;
  logic          last_q;

  addr_t         own_m;
  addr_t         cmp_a;
  logic          cmp_eq;
  logic          later;
  logic          store_ok;
  logic          mem_we;
  logic          last_hit;
  logic          in_acc, out_acc;
  addr_t         reply_hop;

  assign own_m    = own_q & ADDR_MASK;
  // one comparator: record entries while matching, header destination while judging
  assign cmp_a    = (state_q == S_MATCH) ? entry_q : hdr_dst_q;
  assign cmp_eq   = (cmp_a == own_m);
  assign later    = (cnt_q != '0) || ovf_q;
  assign store_ok = !ovf_q && (cnt_q < CW'(MAX_ROUTE));
  assign mem_we   = (state_q == S_MATCH) && store_ok;
  assign last_hit = append_q ? (rd_idx_q == cnt_q) : (rd_idx_q == (cnt_q - CW'(1)));
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign reply_hop = (found_q || (cnt_q >= CW'(2))) ? rhop_q : held_q;

  assign in_stall_o     = (state_q != S_IN);
  assign out_valid_o    = (state_q == S_OUT);
  assign verdict_o      = verdict_q;
  assign type_out_o     = type_q;
  assign source_out_o   = src_out_q;
  assign dest_out_o     = dst_out_q;
  assign route_entry_o  = rentry_q;
  assign route_length_o = len_q;
  assign next_hop_o     = hop_q;
  assign last_o         = last_q;

  // route record store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      route_mem[cnt_q[IW-1:0]] <= entry_q;
    end
    rd_data_q <= route_mem[rd_idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IN;
      own_q      <= '0;
      bcast_q    <= '1;
      entry_q    <= '0;
      last_in_q  <= 1'b0;
      hdr_type_q <= '0;
      hdr_src_q  <= '0;
      hdr_dst_q  <= '0;
      cnt_q      <= '0;
      own_seen_q <= 1'b0;
      found_q    <= 1'b0;
      ovf_q      <= 1'b0;
      prev_q     <= '0;
      rhop_q     <= '0;
      held_q     <= '0;
      append_q   <= 1'b0;
      rd_idx_q   <= '0;
      verdict_q  <= '0;
      type_q     <= '0;
      src_out_q  <= '0;
      dst_out_q  <= '0;
      rentry_q   <= '0;
      hop_q      <= '0;
      len_q      <= '0;
      last_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_OWN_ADDRESS:       own_q   <= cfg_data_i;
          CFG_BROADCAST_ADDRESS: bcast_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IN: begin
          if (in_acc) begin
            entry_q   <= entry_address_i & ADDR_MASK;
            last_in_q <= last_entry_i;
            // header comes from the first entry of a packet only
            if (!later) begin
              hdr_type_q <= packet_type_i;
              hdr_src_q  <= source_address_i & ADDR_MASK;
              hdr_dst_q  <= dest_address_i & ADDR_MASK;
            end
            state_q <= S_MATCH;
          end
        end

        S_MATCH: begin
          if (!found_q && (cnt_q != '0) && !ovf_q) begin
            rhop_q <= prev_q;
          end
          if (cmp_eq) begin
            own_seen_q <= 1'b1;
            if (later) begin
              found_q <= 1'b1;
            end
          end
          if (store_ok) begin
            prev_q <= entry_q;
            cnt_q  <= cnt_q + CW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= last_in_q ? S_JUDGE : S_IN;
        end

        S_JUDGE: begin
          rd_idx_q  <= '0;
          type_q    <= hdr_type_q;
          src_out_q <= hdr_src_q;
          dst_out_q <= hdr_dst_q;
          rentry_q  <= '0;
          hop_q     <= held_q;
          len_q     <= LW'(cnt_q);
          append_q  <= 1'b0;
          last_q    <= 1'b1;
          if (ovf_q) begin
            verdict_q <= VERDICT_OVERFLOW;
            len_q     <= '0;
            state_q   <= S_OUT;
          end else if ((hdr_type_q == PTYPE_REQUEST) && !own_seen_q) begin
            append_q <= 1'b1;
            len_q    <= LW'(cnt_q) + LW'(1);
            last_q   <= 1'b0;
            if (cmp_eq) begin
              // request reached its target: turn it into a reply
              verdict_q <= VERDICT_REPLY;
              type_q    <= PTYPE_REPLY;
              src_out_q <= hdr_dst_q;
              dst_out_q <= hdr_src_q;
              hop_q     <= prev_q;
              held_q    <= prev_q;
            end else begin
              verdict_q <= VERDICT_FORWARD;
              hop_q     <= bcast_q;
              held_q    <= bcast_q;
            end
            state_q <= S_FETCH;
          end else if ((hdr_type_q == PTYPE_REPLY) && !cmp_eq) begin
            verdict_q <= VERDICT_REPLY;
            hop_q     <= reply_hop;
            held_q    <= reply_hop;
            last_q    <= 1'b0;
            state_q   <= S_FETCH;
          end else if (hdr_type_q == PTYPE_ERROR) begin
            verdict_q <= VERDICT_ERROR;
            last_q    <= 1'b0;
            state_q   <= S_FETCH;
          end else if (hdr_type_q == PTYPE_DATA) begin
            verdict_q <= VERDICT_DATA;
            last_q    <= 1'b0;
            state_q   <= S_FETCH;
          end else begin
            // dropped request, finished reply or unknown type
            verdict_q <= VERDICT_DROP;
            state_q   <= S_OUT;
          end
        end

        S_FETCH: begin
          state_q <= S_LOAD;
        end

        S_LOAD: begin
          rentry_q <= (append_q && (rd_idx_q == cnt_q)) ? own_m : rd_data_q;
          last_q   <= last_hit;
          state_q  <= S_OUT;
        end

        S_OUT: begin
          if (out_acc) begin
            if (last_q) begin
              cnt_q      <= '0;
              own_seen_q <= 1'b0;
              rhop_q     <= '0;
              found_q    <= 1'b0;
              ovf_q      <= 1'b0;
              state_q    <= S_IN;
            end else begin
              rd_idx_q <= rd_idx_q + CW'(1);
              state_q  <= S_FETCH;
            end
          end
        end

        default: state_q <= S_IN;
      endcase
    end
  end

  // no input transaction while a result is pending
  a_no_accept_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ROUTE))
    else $error("route count beyond capacity");

  a_overflow_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == VERDICT_OVERFLOW)) |-> (last_o && (route_length_o == '0)))
    else $error("overflow verdict must be a single result of length zero");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> (!in_stall_o && (cnt_q == '0) && !ovf_q))
    else $error("packet state not cleared after final result");

  a_length_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (route_length_o <= LW'(MAX_ROUTE + 1)))
    else $error("route length out of range");

endmodule
